### design/sbus_pkg.sv
// Shared constants and helpers for the S.BUS frame channel decoder.
// No dependencies; imported by sbus_frame_channel_decoder.
package sbus_pkg;

    localparam int FRAME_BYTES  = 25;
    localparam int NUM_CHANNELS = 9;
    localparam int CHAN_W       = 11;
    localparam int BYTE_W       = 8;
    localparam int POS_W        = 5;
    localparam int STORE_BYTES  = 14;
    localparam int PAYLOAD_W    = (STORE_BYTES - 1) * BYTE_W;
    localparam int CHANS_W      = NUM_CHANNELS * CHAN_W;
    localparam int TDATA_W      = ((CHANS_W + 7) / 8) * 8;

    localparam logic [POS_W-1:0]  LAST_POS       = POS_W'(FRAME_BYTES - 1);
    localparam logic [BYTE_W-1:0] START_MARK     = 8'h0F;
    localparam logic [BYTE_W-1:0] END_MARK       = 8'h00;
    localparam logic [CHAN_W-1:0] FAILSAFE_RESET = 11'd1024;

    function automatic logic [CHAN_W-1:0] chan_extract(
        input logic [PAYLOAD_W-1:0] bits,
        input int                   k
    );
        return bits[CHAN_W*k +: CHAN_W];
    endfunction

endpackage

### design/sbus_frame_channel_decoder.sv
// S.BUS frame channel decoder: counts bytes into fixed frames, checks markers,
// unpacks nine 11-bit channels. Depends on sbus_pkg.
//
// Channel   Dir  Signals                               Content
// s_axis    in   tvalid tready tdata[7:0]              rx_byte
// m_axis    out  tvalid tready tdata[103:0] tuser[0]   chan_0..chan_8 / frame_ok
// cfg       in   cfg_valid cfg_ready cfg_data[10:0]    failsafe_value
//
// One byte accepted per cycle; a frame result is registered the cycle after its
// last byte and held until taken. Bytes keep flowing while a result waits, and
// stall only when a new result would overwrite one not yet taken.
// Reset clears the byte position, the result valid and sets failsafe to 1024.
module sbus_frame_channel_decoder
    import sbus_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [BYTE_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [TDATA_W-1:0]  m_axis_tdata,   // chan_0 [10:0] .. chan_8 [98:88], zero pad
    output logic [0:0]          m_axis_tuser,   // [0] frame_ok
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CHAN_W-1:0]   cfg_data        // [10:0] failsafe_value
);

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [BYTE_W-1:0]  byte_reg [STORE_BYTES];
    logic [CHAN_W-1:0]  failsafe_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               ok_reg;
    logic               ok_next;
    logic [CHANS_W-1:0] chans_reg;
    logic [CHANS_W-1:0] chans_next;
    logic [PAYLOAD_W-1:0] payload;
    logic               in_accept;
    logic               frame_end;

    assign s_axis_tready = !out_valid_reg || m_axis_tready || (pos_reg != LAST_POS);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign frame_end     = in_accept && (pos_reg == LAST_POS);
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = ok_reg;
    assign m_axis_tdata  = {{(TDATA_W - CHANS_W){1'b0}}, chans_reg};

    always_comb
    begin
        for (int i = 1; i < STORE_BYTES; i++)
        begin
            payload[BYTE_W*(i-1) +: BYTE_W] = byte_reg[i];
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (in_accept)
        begin
            if (pos_reg >= LAST_POS)
                pos_next = '0;
            else
                pos_next = pos_reg + POS_W'(1);
        end
    end

    always_comb
    begin
        ok_next = (byte_reg[0] == START_MARK) && (s_axis_tdata == END_MARK);
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            chans_next[CHAN_W*k +: CHAN_W] = ok_next ? chan_extract(payload, k) : failsafe_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (frame_end)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            failsafe_reg  <= FAILSAFE_RESET;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                failsafe_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            if (in_accept && (pos_reg == POS_W'(i)))
                byte_reg[i] <= s_axis_tdata;
        end
        if (frame_end)
        begin
            ok_reg    <= ok_next;
            chans_reg <= chans_next;
        end
    end

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("byte position out of frame");

    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> m_axis_tvalid)
        else $error("frame end gave no result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)) |->
            $past(frame_end))
        else $error("result without frame end");

    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> pos_reg == '0)
        else $error("position did not wrap at frame end");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !frame_end)
        else $error("pending result overwritten");
`endif

endmodule

### verif/tb_sbus_frame_channel_decoder.sv
// Self-checking testbench for sbus_frame_channel_decoder: byte stream in, one
// decoded frame per 25 bytes out, checked against an in-bench decoder or typed table rows.
// Depends on sbus_pkg and the decoder RTL only.
module tb_sbus_frame_channel_decoder;
    import sbus_pkg::*;

    typedef struct packed {
        logic                                 ok;
        logic [NUM_CHANNELS-1:0][CHAN_W-1:0] ch;
    } frame_result_t;

    typedef struct packed {
        logic [POS_W-1:0]  len;
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] fill;
        logic [BYTE_W-1:0] last;
        logic              typed;
        logic              ok;
        logic [CHAN_W-1:0] chan;
    } frame_row_t;

    localparam int NUM_PHASES  = 4;
    localparam int PHASE_BYTES = 240;
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_ROWS    = 9;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [0:0]         m_axis_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CHAN_W-1:0]  cfg_data;

    logic [BYTE_W-1:0]  rx_store [FRAME_BYTES];
    int                 rx_pos;
    logic [CHAN_W-1:0]  fs_value;
    frame_result_t      pending_frames [$];
    frame_result_t      typed_result;
    logic               typed_active;
    int                 mismatch_count;
    int                 frames_seen;
    int                 send_idle_pct;
    int                 stall_pct;
    int                 hold_left;

    int send_idle  [NUM_PHASES] = '{0, 65, 0, 11};
    int recv_stall [NUM_PHASES] = '{0, 0, 65, 11};

    frame_row_t dir_rows [NUM_ROWS] = '{
        '{5'd25, START_MARK, 8'h00, END_MARK, 1'b1, 1'b1, 11'd0},
        '{5'd25, START_MARK, 8'hFF, END_MARK, 1'b1, 1'b1, 11'd2047},
        '{5'd25, 8'h0E,      8'hFF, END_MARK, 1'b1, 1'b0, FAILSAFE_RESET},
        '{5'd25, START_MARK, 8'h55, 8'h01,    1'b1, 1'b0, FAILSAFE_RESET},
        '{5'd25, START_MARK, 8'hAA, END_MARK, 1'b0, 1'b0, 11'd0},
        '{5'd25, 8'hFF,      8'hFF, 8'hFF,    1'b1, 1'b0, FAILSAFE_RESET},
        '{5'd13, START_MARK, 8'h3C, END_MARK, 1'b0, 1'b0, 11'd0},
        '{5'd25, START_MARK, 8'hC3, END_MARK, 1'b0, 1'b0, 11'd0},
        '{5'd12, 8'h81,      8'h7E, END_MARK, 1'b0, 1'b0, 11'd0}
    };

    sbus_frame_channel_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic void decode_rx_byte(input logic [BYTE_W-1:0] b);
        frame_result_t        res;
        logic [PAYLOAD_W-1:0] payload;
        rx_store[rx_pos] = b;
        if (rx_pos != FRAME_BYTES - 1)
        begin
            rx_pos++;
            return;
        end
        rx_pos = 0;
        for (int i = 0; i < STORE_BYTES - 1; i++)
            payload[i*BYTE_W +: BYTE_W] = rx_store[i+1];
        res.ok = (rx_store[0] == START_MARK) && (rx_store[FRAME_BYTES-1] == END_MARK);
        for (int k = 0; k < NUM_CHANNELS; k++)
            res.ch[k] = res.ok ? payload[k*CHAN_W +: CHAN_W] : fs_value;
        pending_frames.push_back(typed_active ? typed_result : res);
    endfunction

    task automatic flag_mismatch(input string field, input int got, input int want);
        $display("frame %0d: %s got %0d want %0d", frames_seen, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_frames.size() == 0)
                    flag_mismatch("unexpected frame, frame_ok", m_axis_tuser[0], 0);
                else
                begin
                    want = pending_frames.pop_front();
                    if (m_axis_tuser[0] !== want.ok)
                        flag_mismatch("frame_ok", m_axis_tuser[0], want.ok);
                    for (int k = 0; k < NUM_CHANNELS; k++)
                        if (m_axis_tdata[k*CHAN_W +: CHAN_W] !== want.ch[k])
                            flag_mismatch($sformatf("chan_%0d", k),
                                          m_axis_tdata[k*CHAN_W +: CHAN_W], want.ch[k]);
                end
                frames_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_rx_byte(s_axis_tdata);
            if (cfg_valid && cfg_ready)
                fs_value = cfg_data;
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
                m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic write_failsafe(input logic [CHAN_W-1:0] v);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain_frames();
        s_axis_tvalid = 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic send_random_frame(output int count);
        logic [BYTE_W-1:0] fb [FRAME_BYTES];
        int                kind;
        int                shift;
        kind  = $urandom_range(0, 99);
        shift = 0;
        count = 0;
        foreach (fb[i])
            fb[i] = rand_byte();
        fb[0]             = START_MARK;
        fb[FRAME_BYTES-1] = END_MARK;
        if (kind >= 70 && kind < 85)
        begin
            if ($urandom_range(0, 1))
                fb[0] = rand_byte();
            else
                fb[FRAME_BYTES-1] = rand_byte();
        end
        else if (kind >= 85)
        begin
            shift = $urandom_range(1, FRAME_BYTES - 1);
            repeat (shift) send_byte(rand_byte());
        end
        foreach (fb[i])
            send_byte(fb[i]);
        if (shift != 0)
            repeat (FRAME_BYTES - shift) send_byte(rand_byte());
        count = (shift != 0) ? 2 * FRAME_BYTES : FRAME_BYTES;
    endtask

    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int phase_bytes;
        int n;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        rx_pos         = 0;
        fs_value       = FAILSAFE_RESET;
        typed_active   = 1'b0;
        typed_result   = '0;
        mismatch_count = 0;
        frames_seen    = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_left      = 0;
        foreach (rx_store[i])
            rx_store[i] = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
        begin
            typed_result.ok = dir_rows[r].ok;
            for (int k = 0; k < NUM_CHANNELS; k++)
                typed_result.ch[k] = dir_rows[r].chan;
            typed_active = dir_rows[r].typed;
            for (int i = 0; i < dir_rows[r].len; i++)
                send_byte(i == 0 ? dir_rows[r].first :
                          i == dir_rows[r].len - 1 ? dir_rows[r].last : dir_rows[r].fill);
            typed_active = 1'b0;
        end
        drain_frames();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: write_failsafe(11'd2047);
                1: write_failsafe(11'd0);
                default: write_failsafe(CHAN_W'($urandom_range(1, 2046)));
            endcase
            send_idle_pct = send_idle[p];
            stall_pct     = recv_stall[p];
            if (p == 0)
                hold_left = HOLD_CYCLES;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                send_random_frame(n);
                phase_bytes += n;
            end
            drain_frames();
        end

        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
design/sbus_pkg.sv
design/sbus_frame_channel_decoder.sv
verif/tb_sbus_frame_channel_decoder.sv
